[hw/rtl/pbrc_pkg.sv]
// pbrc_pkg: shared types, codes and reset values of the pi buffer rate controller
// used by pbrc_div and pi_buffer_rate_control_qp
`default_nettype none

package pbrc_pkg;

    localparam int SAD_WIDTH   = 40;
    localparam int SCALE_W     = SAD_WIDTH + 4;
    localparam int DIVIDEND_W  = 42;
    localparam int DIVISOR_W   = 34;
    localparam int DIV_STEPS   = DIVIDEND_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_CBR = 2'd0;
    localparam logic [1:0] MODE_VBR = 2'd1;
    localparam logic [1:0] MODE_CQP = 2'd2;
    localparam logic [1:0] MODE_LLT = 2'd3;

    localparam logic CMD_GET_QP = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_QUOTA       = 3'd1;
    localparam logic [2:0] REG_BUCKET_SIZE = 3'd2;
    localparam logic [2:0] REG_BASE_QP     = 3'd3;
    localparam logic [2:0] REG_QP_FLOOR    = 3'd4;
    localparam logic [2:0] REG_QP_CEILING  = 3'd5;
    localparam logic [2:0] REG_FRAME_LIMIT = 3'd6;
    localparam logic [2:0] REG_SPEED       = 3'd7;

    localparam logic [1:0]  RST_MODE        = MODE_CBR;
    localparam logic [31:0] RST_QUOTA       = 32'd83333;
    localparam logic [31:0] RST_BUCKET_SIZE = 32'd5000000;
    localparam logic [5:0]  RST_BASE_QP     = 6'd26;
    localparam logic [5:0]  RST_QP_FLOOR    = 6'd12;
    localparam logic [5:0]  RST_QP_CEILING  = 6'd51;
    localparam logic [31:0] RST_FRAME_LIMIT = 32'd0;
    localparam logic [2:0]  RST_SPEED       = 3'd4;
    localparam logic [31:0] RST_FULLNESS    = RST_BUCKET_SIZE >> 1;

    typedef struct packed {
        logic                 cmd;
        logic [SAD_WIDTH-1:0] frame_sad;
        logic [30:0]          coded_bits;
    } in_t;

    typedef struct packed {
        logic [5:0]  qp;
        logic [31:0] bucket_level;
    } out_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/pi_buffer_rate_control_qp.sv]
// pi_buffer_rate_control_qp: leaky-bucket pi rate controller, one request at a time
// get-qp request: err, sum, clamp, num, dstart, 42-step serial divide, adj, delta, final, done
// update request: upd, then done; constant-qp mode: done; one request in flight at most
// next request is taken from the cycle out_valid rises; done waits while the output stalls
// reset: registers to defaults, fullness 2500000, error sum 0, qp 26, last sad 0
// depends on pbrc_pkg and pbrc_div
`default_nettype none

module pi_buffer_rate_control_qp
    import pbrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ERR    = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_CLAMP  = 4'd3;
    localparam logic [3:0] S_NUM    = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_ADJ    = 4'd7;
    localparam logic [3:0] S_DELTA  = 4'd8;
    localparam logic [3:0] S_FINAL  = 4'd9;
    localparam logic [3:0] S_UPD    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]  state_reg;

    logic [1:0]  mode_reg;
    logic [31:0] quota_reg;
    logic [31:0] bsize_reg;
    logic [5:0]  base_reg;
    logic [5:0]  floor_reg;
    logic [5:0]  ceil_reg;
    logic [31:0] limit_reg;
    logic [2:0]  speed_reg;

    logic [31:0]          fullness_reg;
    logic signed [37:0]   esum_reg;
    logic [5:0]           qp_now_reg;
    logic [SAD_WIDTH-1:0] last_sad_reg;

    logic                 out_valid_reg;
    out_t                 out_reg;

    in_t                  req_reg;
    logic signed [33:0]   err_reg;
    logic signed [38:0]   acc_reg;
    logic signed [40:0]   num_reg;
    logic                 neg_reg;
    logic signed [3:0]    bias_reg;
    logic signed [43:0]   adj_reg;
    logic signed [44:0]   delta_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [30:0]          t_w;
    logic [35:0]          cap_w;
    logic signed [38:0]   cap_s;
    logic                 sat_w;
    logic signed [40:0]   err_x;
    logic signed [40:0]   es_x;
    logic [40:0]          mag_w;
    logic [32:0]          den_w;
    logic [SCALE_W-1:0]   sad10_w;
    logic [SCALE_W-1:0]   last13_w;
    logic [SCALE_W-1:0]   last7_w;
    logic signed [3:0]    vbr_bias_w;
    logic signed [3:0]    fs_bias_w;
    logic [32:0]          q15_w;
    logic signed [43:0]   qx_w;
    logic [2:0]           step_w;
    logic signed [44:0]   step_s;
    logic signed [3:0]    dsmall_w;
    logic signed [7:0]    nq_w;
    logic signed [33:0]   f_w;
    logic [31:0]          f_clamped;
    logic                 out_free;

    assign out_free = !out_valid_reg || !out_stall;

    assign t_w   = (bsize_reg[31:1] == 31'd0) ? 31'd1 : bsize_reg[31:1];
    assign cap_w = (36'(t_w) << 5) - (36'(t_w) << 1);
    assign cap_s = $signed({3'b000, cap_w});
    assign den_w = 33'(t_w) + {1'b0, t_w, 1'b0};

    assign sat_w = ((qp_now_reg >= ceil_reg) && !err_reg[33] && (err_reg != '0))
                || ((qp_now_reg <= floor_reg) && err_reg[33]);

    assign err_x = {{7{err_reg[33]}}, err_reg};
    assign es_x  = {{3{esum_reg[37]}}, esum_reg};
    assign mag_w = num_reg[40] ? 41'(-num_reg) : 41'(num_reg);

    assign sad10_w  = (SCALE_W'(req_reg.frame_sad) << 3) + (SCALE_W'(req_reg.frame_sad) << 1);
    assign last13_w = (SCALE_W'(last_sad_reg) << 3) + (SCALE_W'(last_sad_reg) << 2)
                    + SCALE_W'(last_sad_reg);
    assign last7_w  = (SCALE_W'(last_sad_reg) << 3) - SCALE_W'(last_sad_reg);

    always_comb
    begin
        vbr_bias_w = 4'sd0;
        if ((mode_reg == MODE_VBR) && (last_sad_reg != '0))
        begin
            priority if (sad10_w > last13_w)
                vbr_bias_w = 4'sd2;
            else if (sad10_w < last7_w)
                vbr_bias_w = -4'sd2;
        end
    end

    assign q15_w = {1'b0, quota_reg} + {2'b00, quota_reg[31:1]};

    always_comb
    begin
        fs_bias_w = 4'sd0;
        if ((limit_reg != '0) && (quota_reg != '0))
        begin
            priority if (quota_reg > limit_reg)
                fs_bias_w = 4'sd2;
            else if ({1'b0, limit_reg} < q15_w)
                fs_bias_w = 4'sd1;
        end
    end

    assign qx_w = $signed({2'b00, div_rsp.quotient});

    always_comb
    begin
        step_w = ((mode_reg == MODE_LLT) || (speed_reg >= 3'd5)) ? 3'd3 : 3'd2;
        priority if ((delta_reg >= 45'sd8) || (delta_reg <= -45'sd8))
            step_w = step_w + 3'd2;
        else if ((delta_reg >= 45'sd4) || (delta_reg <= -45'sd4))
            step_w = step_w + 3'd1;
        step_s = $signed({42'd0, step_w});
        priority if (delta_reg > step_s)
            dsmall_w = $signed({1'b0, step_w});
        else if (delta_reg < -step_s)
            dsmall_w = -$signed({1'b0, step_w});
        else
            dsmall_w = delta_reg[3:0];
        nq_w = $signed({2'b00, qp_now_reg}) + 8'(dsmall_w);
        if (nq_w < $signed({2'b00, floor_reg}))
            nq_w = $signed({2'b00, floor_reg});
        if (nq_w > $signed({2'b00, ceil_reg}))
            nq_w = $signed({2'b00, ceil_reg});
        if (nq_w < 8'sd0)
            nq_w = 8'sd0;
    end

    always_comb
    begin
        f_w = $signed({2'b00, fullness_reg}) + $signed({3'b000, req_reg.coded_bits})
            - $signed({2'b00, quota_reg});
        priority if (f_w[33])
            f_clamped = '0;
        else if (f_w > $signed({2'b00, bsize_reg}))
            f_clamped = bsize_reg;
        else
            f_clamped = f_w[31:0];
    end

    assign div_req.start    = (state_reg == S_DSTART);
    assign div_req.dividend = {mag_w, 1'b0} + 42'(den_w);
    assign div_req.divisor  = {den_w, 1'b0};

    pbrc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= RST_MODE;
            quota_reg     <= RST_QUOTA;
            bsize_reg     <= RST_BUCKET_SIZE;
            base_reg      <= RST_BASE_QP;
            floor_reg     <= RST_QP_FLOOR;
            ceil_reg      <= RST_QP_CEILING;
            limit_reg     <= RST_FRAME_LIMIT;
            speed_reg     <= RST_SPEED;
            fullness_reg  <= RST_FULLNESS;
            esum_reg      <= '0;
            qp_now_reg    <= RST_BASE_QP;
            last_sad_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        priority if (mode_reg == MODE_CQP)
                            state_reg <= S_DONE;
                        else if (in_data.cmd == CMD_UPDATE)
                            state_reg <= S_UPD;
                        else
                            state_reg <= S_ERR;
                    end
                end
                S_ERR:    state_reg <= S_SUM;
                S_SUM:    state_reg <= S_CLAMP;
                S_CLAMP:
                begin
                    // anti-windup: a held integral is kept as it is
                    if (!sat_w && (acc_reg > cap_s))
                        esum_reg <= cap_s[37:0];
                    else if (!sat_w && (acc_reg < -cap_s))
                        esum_reg <= 38'(-cap_s);
                    else
                        esum_reg <= acc_reg[37:0];
                    state_reg <= S_NUM;
                end
                S_NUM:    state_reg <= S_DSTART;
                S_DSTART: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_rsp.done)
                        state_reg <= S_ADJ;
                end
                S_ADJ:    state_reg <= S_DELTA;
                S_DELTA:  state_reg <= S_FINAL;
                S_FINAL:
                begin
                    qp_now_reg   <= nq_w[5:0];
                    last_sad_reg <= req_reg.frame_sad;
                    state_reg    <= S_DONE;
                end
                S_UPD:
                begin
                    fullness_reg <= f_clamped;
                    state_reg    <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:        mode_reg  <= cfg_data[1:0];
                    REG_QUOTA:       quota_reg <= cfg_data;
                    REG_BUCKET_SIZE:
                    begin
                        bsize_reg    <= cfg_data;
                        fullness_reg <= {1'b0, cfg_data[31:1]};
                    end
                    REG_BASE_QP:
                    begin
                        base_reg   <= cfg_data[5:0];
                        qp_now_reg <= cfg_data[5:0];
                    end
                    REG_QP_FLOOR:    floor_reg <= cfg_data[5:0];
                    REG_QP_CEILING:  ceil_reg  <= cfg_data[5:0];
                    REG_FRAME_LIMIT: limit_reg <= cfg_data;
                    REG_SPEED:       speed_reg <= cfg_data[2:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
            req_reg <= in_data;
        if (state_reg == S_ERR)
        begin
            err_reg  <= $signed({2'b00, fullness_reg}) - $signed({3'b000, t_w});
            bias_reg <= vbr_bias_w + fs_bias_w;
        end
        if (state_reg == S_SUM)
            acc_reg <= sat_w ? $signed({esum_reg[37], esum_reg})
                             : $signed({esum_reg[37], esum_reg})
                               + $signed({{5{err_reg[33]}}, err_reg});
        if (state_reg == S_NUM)
            num_reg <= (err_x <<< 4) + (err_x <<< 1) + (es_x <<< 2);
        if (state_reg == S_DSTART)
            neg_reg <= num_reg[40];
        if (state_reg == S_ADJ)
            adj_reg <= (neg_reg ? -qx_w : qx_w) + 44'(bias_reg);
        if (state_reg == S_DELTA)
            delta_reg <= 45'(adj_reg) + $signed({39'd0, base_reg})
                       - $signed({39'd0, qp_now_reg});
        if ((state_reg == S_DONE) && out_free)
        begin
            out_reg.qp           <= qp_now_reg;
            out_reg.bucket_level <= fullness_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

[hw/rtl/pbrc_div.sv]
// pbrc_div: restoring unsigned divider, one quotient bit per cycle
// depends on pbrc_pkg
`default_nettype none

module pbrc_div
    import pbrc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  fits;

    assign rem_sh = {rem_reg[DIVISOR_W-1:0], dq_reg[DIVIDEND_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

`default_nettype wire

[tb/pi_buffer_rate_control_qp_tb.sv]
// pi_buffer_rate_control_qp_tb: self-checking bench for the pi buffer rate controller
// drives get-qp and update requests under random stalls and checks qp and bucket level
// depends on pbrc_pkg and pi_buffer_rate_control_qp
`timescale 1ns / 1ps
`default_nettype none

module pi_buffer_rate_control_qp_tb;
    import pbrc_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES = 11;
    localparam logic [63:0] SAD_MAX = (64'd1 << SAD_WIDTH) - 64'd1;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  index;
        logic [31:0] value;
        in_t         req;
        logic        typed;
        out_t        want;
    } plan_row_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] quota;
        logic [31:0] bucket;
        logic [5:0]  base;
        logic [5:0]  floor_qp;
        logic [5:0]  ceil_qp;
        logic [31:0] limit;
        logic [2:0]  speed;
        logic [9:0]  count;
    } phase_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;

    // controller copy: configuration and state
    logic [1:0]           rc_mode = RST_MODE;
    logic [31:0]          rc_quota = RST_QUOTA;
    logic [31:0]          rc_bucket = RST_BUCKET_SIZE;
    logic [5:0]           rc_base = RST_BASE_QP;
    logic [5:0]           rc_floor = RST_QP_FLOOR;
    logic [5:0]           rc_ceil = RST_QP_CEILING;
    logic [31:0]          rc_limit = RST_FRAME_LIMIT;
    logic [2:0]           rc_speed = RST_SPEED;
    logic [31:0]          rc_fullness = RST_FULLNESS;
    longint               rc_err_sum = 0;
    logic [5:0]           rc_qp = RST_BASE_QP;
    logic [SAD_WIDTH-1:0] rc_last_sad = '0;

    out_t                 qp_level_q[$];
    plan_row_t            plan_q[$];
    int                   mismatches = 0;
    int                   quiet = 0;
    int                   burst_left = 8;
    int                   pull_center = 12;
    logic [SAD_WIDTH-1:0] drv_last_sad = '0;

    pi_buffer_rate_control_qp u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_MODE:        rc_mode = val[1:0];
            REG_QUOTA:       rc_quota = val;
            REG_BUCKET_SIZE:
            begin
                rc_bucket = val;
                rc_fullness = val >> 1;
            end
            REG_BASE_QP:
            begin
                rc_base = val[5:0];
                rc_qp = val[5:0];
            end
            REG_QP_FLOOR:    rc_floor = val[5:0];
            REG_QP_CEILING:  rc_ceil = val[5:0];
            REG_FRAME_LIMIT: rc_limit = val;
            REG_SPEED:       rc_speed = val[2:0];
            default: ;
        endcase
    endfunction

    function automatic out_t next_qp_level(in_t req);
        longint          t, err, cap, num, adj, step, delta, mag_d, nq, f;
        longint unsigned den, mag, quo, s10, l13, l7, q15;
        out_t            res;
        if (rc_mode != MODE_CQP)
        begin
            if (req.cmd == CMD_GET_QP)
            begin
                t = rc_bucket >> 1;
                if (t == 0)
                    t = 1;
                err = rc_fullness - t;
                cap = 30 * t;
                if (!((rc_qp >= rc_ceil && err > 0) || (rc_qp <= rc_floor && err < 0)))
                begin
                    rc_err_sum = rc_err_sum + err;
                    if (rc_err_sum > cap)
                        rc_err_sum = cap;
                    if (rc_err_sum < -cap)
                        rc_err_sum = -cap;
                end
                num = 18 * err + 4 * rc_err_sum;
                den = 3 * t;
                mag = (num < 0) ? -num : num;
                quo = (2 * mag + den) / (2 * den);
                adj = quo;
                if (num < 0)
                    adj = -adj;
                // complexity bias against the previous frame
                if (rc_mode == MODE_VBR && rc_last_sad != 0)
                begin
                    s10 = req.frame_sad;
                    s10 = s10 * 10;
                    l13 = rc_last_sad;
                    l7 = l13 * 7;
                    l13 = l13 * 13;
                    if (s10 > l13)
                        adj = adj + 2;
                    else if (s10 < l7)
                        adj = adj - 2;
                end
                q15 = rc_quota;
                q15 = q15 * 3 / 2;
                if (rc_limit != 0 && rc_quota != 0)
                begin
                    if (rc_quota > rc_limit)
                        adj = adj + 2;
                    else if (rc_limit < q15)
                        adj = adj + 1;
                end
                step = (rc_mode == MODE_LLT || rc_speed >= 5) ? 3 : 2;
                delta = rc_base;
                delta = delta + adj;
                nq = rc_qp;
                delta = delta - nq;
                mag_d = (delta < 0) ? -delta : delta;
                if (mag_d >= 8)
                    step = step + 2;
                else if (mag_d >= 4)
                    step = step + 1;
                if (delta > step)
                    delta = step;
                if (delta < -step)
                    delta = -step;
                nq = nq + delta;
                // floor first, then ceiling
                f = rc_floor;
                if (nq < f)
                    nq = f;
                f = rc_ceil;
                if (nq > f)
                    nq = f;
                if (nq < 0)
                    nq = 0;
                rc_qp = nq[5:0];
                rc_last_sad = req.frame_sad;
            end
            else
            begin
                f = rc_fullness;
                f = f + req.coded_bits;
                f = f - rc_quota;
                t = rc_bucket;
                if (f < 0)
                    f = 0;
                else if (f > t)
                    f = t;
                rc_fullness = f[31:0];
            end
        end
        res.qp = rc_qp;
        res.bucket_level = rc_fullness;
        return res;
    endfunction

    function automatic void plan_cfg(logic [2:0] idx, logic [31:0] val);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.index = idx;
        row.value = val;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_req(logic c, logic [SAD_WIDTH-1:0] sad, logic [30:0] bits);
        plan_row_t row;
        row = '0;
        row.req.cmd = c;
        row.req.frame_sad = sad;
        row.req.coded_bits = bits;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_chk(logic c, logic [SAD_WIDTH-1:0] sad, logic [30:0] bits,
                                     logic [5:0] qp, logic [31:0] level);
        plan_row_t row;
        row = '0;
        row.req.cmd = c;
        row.req.frame_sad = sad;
        row.req.coded_bits = bits;
        row.typed = 1'b1;
        row.want.qp = qp;
        row.want.bucket_level = level;
        plan_q.push_back(row);
    endfunction

    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_item(in_t req, logic typed, out_t want);
        out_t model_res;
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        model_res = next_qp_level(req);
        qp_level_q.push_back(typed ? want : model_res);
        pace();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (qp_level_q.size() != 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        apply_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_traffic(int n);
        in_t             req;
        logic            next_cmd;
        longint unsigned w;
        int              r;
        next_cmd = CMD_GET_QP;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                pull_center = $urandom_range(0, 20);
            req.cmd = next_cmd;
            if ($urandom_range(0, 9) == 0)
                req.cmd = 1'($urandom_range(0, 1));
            next_cmd = ~req.cmd;
            // sad: mostly near the previous frame, around the vbr thresholds
            r = $urandom_range(0, 99);
            if (r < 15)
                w = {$urandom, $urandom};
            else if (r < 20)
                w = 0;
            else
            begin
                w = drv_last_sad;
                if (w == 0)
                    w = $urandom_range(1, 1 << 20);
                if (r < 35)
                    w = (w / 10) * ($urandom_range(0, 1) ? 13 : 7) + $urandom_range(0, 2) - 1;
                else
                begin
                    w = w * $urandom_range(50, 160) / 100;
                    if (r < 60)
                        w = w / 10 * 10;
                end
                if (w > SAD_MAX)
                    w = SAD_MAX;
            end
            req.frame_sad = w[SAD_WIDTH-1:0];
            // coded bits: mostly the quota scaled by a factor that drifts over time
            r = $urandom_range(0, 99);
            if (r < 12)
                w = $urandom;
            else if (r < 16)
                w = 0;
            else if (r < 19)
                w = 64'h7FFF_FFFF;
            else
            begin
                w = rc_quota;
                w = w * $urandom_range(pull_center, pull_center + 8) / 12;
                if (w > 64'h7FFF_FFFF)
                    w = 64'h7FFF_FFFF;
            end
            req.coded_bits = w[30:0];
            if (req.cmd == CMD_GET_QP)
                drv_last_sad = req.frame_sad;
            send_item(req, 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (qp_level_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: qp %0d level %0d",
                             out_data.qp, out_data.bucket_level);
            end
            else
            begin
                exp_res = qp_level_q.pop_front();
                if (out_data.qp !== exp_res.qp || out_data.bucket_level !== exp_res.bucket_level)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected qp %0d level %0d, got qp %0d level %0d",
                                 exp_res.qp, exp_res.bucket_level,
                                 out_data.qp, out_data.bucket_level);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("[pi_buffer_rate_control_qp] ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold now and then
    initial
    begin
        int seg;
        int len;
        int pct;
        out_stall = 1'b0;
        seg = 0;
        @(posedge rst_n);
        forever
        begin
            seg++;
            if (seg % 30 == 3)
            begin
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                len = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0: pct = 0;
                    1: pct = 20;
                    2: pct = 50;
                    default: pct = 85;
                endcase
                for (int i = 0; i < len; i++)
                begin
                    @(posedge clk);
                    out_stall <= ($urandom_range(0, 99) < pct);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        phase_t          ph;
        longint unsigned lim;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values and field extremes
        plan_chk(CMD_GET_QP, '0, 31'd0, 6'd26, 32'd2500000);
        plan_chk(CMD_UPDATE, '0, 31'd83333, 6'd26, 32'd2500000);
        plan_chk(CMD_UPDATE, '1, 31'h7FFF_FFFF, 6'd26, 32'd5000000);
        plan_req(CMD_GET_QP, '1, 31'h7FFF_FFFF);
        plan_req(CMD_UPDATE, '0, 31'd0);
        plan_req(CMD_GET_QP, 40'h55_5555_5555, 31'h2AAA_AAAA);
        plan_req(CMD_UPDATE, 40'hAA_AAAA_AAAA, 31'h5555_5555);
        // complexity bias, exact threshold ratios included
        plan_cfg(REG_MODE, {30'd0, MODE_VBR});
        plan_req(CMD_GET_QP, 40'd1000, 31'd0);
        plan_req(CMD_GET_QP, 40'd1300, 31'd0);
        plan_req(CMD_GET_QP, 40'd1691, 31'd0);
        plan_req(CMD_GET_QP, 40'd1690, 31'd0);
        plan_req(CMD_GET_QP, 40'd1183, 31'd0);
        plan_req(CMD_GET_QP, 40'd828, 31'd0);
        // frame size bias: above limit, within 1.5x, at 1.5x
        plan_cfg(REG_FRAME_LIMIT, 32'd60000);
        plan_req(CMD_GET_QP, 40'd828, 31'd0);
        plan_cfg(REG_FRAME_LIMIT, 32'd100000);
        plan_req(CMD_GET_QP, 40'd828, 31'd0);
        plan_cfg(REG_FRAME_LIMIT, 32'd124999);
        plan_req(CMD_GET_QP, 40'd828, 31'd0);
        plan_cfg(REG_MODE, {30'd0, MODE_LLT});
        plan_req(CMD_GET_QP, 40'd900, 31'd0);
        plan_cfg(REG_SPEED, 32'd7);
        plan_req(CMD_GET_QP, 40'd900, 31'd0);
        // constant qp
        plan_cfg(REG_MODE, {30'd0, MODE_CQP});
        plan_req(CMD_GET_QP, 40'd0, 31'd0);
        plan_req(CMD_UPDATE, 40'd0, 31'h7FFF_FFFF);
        // tiny bucket, floor above ceiling
        plan_cfg(REG_MODE, {30'd0, MODE_CBR});
        plan_cfg(REG_BUCKET_SIZE, 32'd1);
        plan_cfg(REG_QP_FLOOR, 32'd40);
        plan_cfg(REG_QP_CEILING, 32'd20);
        plan_chk(CMD_GET_QP, 40'd5000, 31'd0, 6'd20, 32'd0);
        plan_chk(CMD_UPDATE, 40'd0, 31'h7FFF_FFFF, 6'd20, 32'd1);
        // zero floor, qp driven toward zero
        plan_cfg(REG_BUCKET_SIZE, 32'd1000);
        plan_cfg(REG_QUOTA, 32'd100);
        plan_cfg(REG_QP_FLOOR, 32'd0);
        plan_cfg(REG_QP_CEILING, 32'd51);
        plan_cfg(REG_BASE_QP, 32'd1);
        plan_chk(CMD_UPDATE, 40'd0, 31'd0, 6'd1, 32'd400);
        plan_req(CMD_UPDATE, 40'd0, 31'd0);
        plan_req(CMD_GET_QP, 40'd7, 31'd0);
        plan_req(CMD_GET_QP, 40'd7, 31'd0);
        plan_req(CMD_GET_QP, 40'd7, 31'd0);

        foreach (plan_q[i])
        begin
            if (plan_q[i].is_cfg)
            begin
                wait_idle();
                write_reg(plan_q[i].index, plan_q[i].value);
            end
            else
                send_item(plan_q[i].req, plan_q[i].typed, plan_q[i].want);
        end

        for (int p = 1; p <= NUM_PHASES; p++)
        begin
            case (p)
                1: ph = '{MODE_VBR, 32'd83333, 32'd5000000, 6'd30, 6'd10, 6'd45,
                          32'd0, 3'd4, 10'd110};
                2: ph = '{MODE_LLT, 32'd20000, 32'd400000, 6'd22, 6'd18, 6'd40,
                          32'd25000, 3'd2, 10'd90};
                3: ph = '{MODE_CBR, 32'd100, 32'd1000, 6'd51, 6'd1, 6'd51,
                          32'd50, 3'd7, 10'd90};
                4: ph = '{MODE_VBR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd1, 6'd1, 6'd51,
                          32'hFFFF_FFFF, 3'd1, 10'd80};
                5: ph = '{MODE_CQP, 32'd5000, 32'd100000, 6'd33, 6'd12, 6'd51,
                          32'd0, 3'd4, 10'd50};
                6: ph = '{MODE_CBR, 32'd40000, 32'd2000000, 6'd30, 6'd40, 6'd20,
                          32'd0, 3'd5, 10'd50};
                7: ph = '{MODE_VBR, 32'd500, 32'd1000, 6'd1, 6'd0, 6'd51,
                          32'd600, 3'd3, 10'd60};
                8: ph = '{MODE_LLT, 32'd100, 32'd0, 6'd40, 6'd1, 6'd51,
                          32'd0, 3'd1, 10'd50};
                9: ph = '{MODE_CBR, 32'd100000, 32'd3000000, 6'd35, 6'd5, 6'd50,
                          32'd120000, 3'd6, 10'd90};
                default:
                begin
                    ph.mode = 2'($urandom_range(0, 3));
                    ph.bucket = $urandom_range(1000, 32'hFFFF_FFFF);
                    ph.quota = $urandom_range(100, ph.bucket / 16 + 100);
                    ph.base = 6'($urandom_range(1, 51));
                    ph.floor_qp = 6'($urandom_range(1, 51));
                    ph.ceil_qp = 6'($urandom_range(1, 51));
                    lim = ph.quota;
                    lim = lim * $urandom_range(50, 200) / 100;
                    if (lim > 64'hFFFF_FFFF)
                        lim = 64'hFFFF_FFFF;
                    ph.limit = $urandom_range(0, 1) ? 32'd0 : lim[31:0];
                    ph.speed = 3'($urandom_range(1, 7));
                    ph.count = 10'd80;
                end
            endcase
            wait_idle();
            write_reg(REG_MODE, {30'd0, ph.mode});
            write_reg(REG_QUOTA, ph.quota);
            write_reg(REG_BUCKET_SIZE, ph.bucket);
            write_reg(REG_BASE_QP, {26'd0, ph.base});
            write_reg(REG_QP_FLOOR, {26'd0, ph.floor_qp});
            write_reg(REG_QP_CEILING, {26'd0, ph.ceil_qp});
            write_reg(REG_FRAME_LIMIT, ph.limit);
            write_reg(REG_SPEED, {29'd0, ph.speed});
            drv_last_sad = rc_last_sad;
            run_traffic(ph.count);
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("[pi_buffer_rate_control_qp] OK");
        else
            $display("[pi_buffer_rate_control_qp] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
